// ----- rtl/core/nmea_chk_pkg.sv -----
// Shared types, constants and helper functions for the NMEA sentence checker.
// Used by nmea_chk_line, nmea_chk_verdict and nmea_sentence_checker_core.
// No dependencies.
package nmea_chk_pkg;

    // Line buffer size in bytes; a line holds at most LINE_BUFFER_BYTES-1 bytes.
    localparam int LINE_BUFFER_BYTES = 512;
    localparam int LINE_LEN_W        = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LINE_LEN_W-1:0] LINE_LEN_MAX = LINE_LEN_W'(LINE_BUFFER_BYTES - 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam int NUM_TYPES = 6;

    typedef enum logic [2:0] {
        TYPE_GGA   = 3'd0,
        TYPE_RMC   = 3'd1,
        TYPE_VTG   = 3'd2,
        TYPE_GSA   = 3'd3,
        TYPE_ZDA   = 3'd4,
        TYPE_GST   = 3'd5,
        TYPE_OTHER = 3'd6
    } sentence_type_t;

    typedef enum logic [1:0] {
        CHECK_NONE     = 2'd0,
        CHECK_MATCH    = 2'd1,
        CHECK_MISMATCH = 2'd2
    } check_status_t;

    // Three-character sentence codes, first character in the top byte.
    localparam logic [NUM_TYPES-1:0][23:0] TYPE_CODES = {
        {"G", "S", "T"},
        {"Z", "D", "A"},
        {"G", "S", "A"},
        {"V", "T", "G"},
        {"R", "M", "C"},
        {"G", "G", "A"}
    };

    // State of the line being assembled, as seen by the verdict logic.
    typedef struct packed {
        logic [LINE_LEN_W-1:0] length;
        logic                  starts_dollar;
        logic [7:0]            running_xor;
        logic                  star_seen;
        logic                  hex_digit_seen;
        logic [7:0]            hex_acc;
        logic                  hex_too_large;
        logic [1:0]            field_len;
        logic [23:0]           last_three;
    } line_state_t;

    typedef struct packed {
        sentence_type_t sentence_type;
        check_status_t  check_status;
        logic [7:0]     computed_sum;
        logic [7:0]     received_sum;
    } verdict_t;

    // Returns {is_hex, digit value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b >= "0" && b <= "9") begin
            res = {1'b1, 4'(b - "0")};
        end else if (b >= "A" && b <= "F") begin
            res = {1'b1, 4'(b - "A" + 8'd10)};
        end else if (b >= "a" && b <= "f") begin
            res = {1'b1, 4'(b - "a" + 8'd10)};
        end
        return res;
    endfunction

    function automatic sentence_type_t classify(input logic [23:0] code);
        sentence_type_t res;
        res = TYPE_OTHER;
        // Walk downward so the lowest matching index wins.
        for (int i = NUM_TYPES - 1; i >= 0; i--) begin
            if (TYPE_CODES[i] == code) begin
                res = sentence_type_t'(3'(i));
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/nmea_chk_line.sv -----
// Line framing and per-line running state (XOR, hex field, first field).
// Depends on nmea_chk_pkg.
module nmea_chk_line (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_en,
    input  logic [7:0]                rx_byte,
    output nmea_chk_pkg::line_state_t line_state
);

    logic [nmea_chk_pkg::LINE_LEN_W-1:0] length_reg, length_next;
    logic        starts_dollar_reg, starts_dollar_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic        star_seen_reg, star_seen_next;
    logic        reading_hex_reg, reading_hex_next;
    logic        hex_digit_seen_reg, hex_digit_seen_next;
    logic [7:0]  hex_acc_reg, hex_acc_next;
    logic        hex_too_large_reg, hex_too_large_next;
    logic        field_open_reg, field_open_next;
    logic [1:0]  field_len_reg, field_len_next;
    logic [23:0] last_three_reg, last_three_next;

    logic [4:0]  hex_dec;
    logic        clear_line;

    assign hex_dec = nmea_chk_pkg::hex_decode(rx_byte);

    // A newline ends the line; a byte beyond the buffer limit resets it and is dropped.
    assign clear_line = (rx_byte == nmea_chk_pkg::CH_LF) ||
                        (length_reg >= nmea_chk_pkg::LINE_LEN_MAX);

    always_comb begin
        length_next         = length_reg;
        starts_dollar_next  = starts_dollar_reg;
        running_xor_next    = running_xor_reg;
        star_seen_next      = star_seen_reg;
        reading_hex_next    = reading_hex_reg;
        hex_digit_seen_next = hex_digit_seen_reg;
        hex_acc_next        = hex_acc_reg;
        hex_too_large_next  = hex_too_large_reg;
        field_open_next     = field_open_reg;
        field_len_next      = field_len_reg;
        last_three_next     = last_three_reg;

        if (clear_line) begin
            length_next         = '0;
            starts_dollar_next  = 1'b0;
            running_xor_next    = 8'd0;
            star_seen_next      = 1'b0;
            reading_hex_next    = 1'b0;
            hex_digit_seen_next = 1'b0;
            hex_acc_next        = 8'd0;
            hex_too_large_next  = 1'b0;
            field_open_next     = 1'b1;
            field_len_next      = 2'd0;
            last_three_next     = 24'd0;
        end else begin
            if (length_reg == '0) begin
                starts_dollar_next = (rx_byte == nmea_chk_pkg::CH_DOLLAR);
            end else if (!star_seen_reg) begin
                if (rx_byte == nmea_chk_pkg::CH_STAR) begin
                    star_seen_next   = 1'b1;
                    reading_hex_next = 1'b1;
                end else begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                end
            end else if (reading_hex_reg) begin
                if (!hex_dec[4]) begin
                    reading_hex_next = 1'b0;
                end else begin
                    if (hex_acc_reg[7:4] != 4'd0) begin
                        hex_too_large_next = 1'b1;
                    end
                    hex_acc_next        = {hex_acc_reg[3:0], hex_dec[3:0]};
                    hex_digit_seen_next = 1'b1;
                end
            end

            if (field_open_reg) begin
                if (rx_byte == nmea_chk_pkg::CH_COMMA || rx_byte == nmea_chk_pkg::CH_STAR ||
                    rx_byte == nmea_chk_pkg::CH_CR) begin
                    field_open_next = 1'b0;
                end else begin
                    last_three_next = {last_three_reg[15:0], rx_byte};
                    if (field_len_reg != 2'd3) begin
                        field_len_next = field_len_reg + 2'd1;
                    end
                end
            end

            length_next = length_reg + nmea_chk_pkg::LINE_LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg         <= '0;
            starts_dollar_reg  <= 1'b0;
            running_xor_reg    <= 8'd0;
            star_seen_reg      <= 1'b0;
            reading_hex_reg    <= 1'b0;
            hex_digit_seen_reg <= 1'b0;
            hex_acc_reg        <= 8'd0;
            hex_too_large_reg  <= 1'b0;
            field_open_reg     <= 1'b1;
            field_len_reg      <= 2'd0;
            last_three_reg     <= 24'd0;
        end else if (byte_en) begin
            length_reg         <= length_next;
            starts_dollar_reg  <= starts_dollar_next;
            running_xor_reg    <= running_xor_next;
            star_seen_reg      <= star_seen_next;
            reading_hex_reg    <= reading_hex_next;
            hex_digit_seen_reg <= hex_digit_seen_next;
            hex_acc_reg        <= hex_acc_next;
            hex_too_large_reg  <= hex_too_large_next;
            field_open_reg     <= field_open_next;
            field_len_reg      <= field_len_next;
            last_three_reg     <= last_three_next;
        end
    end

    always_comb begin
        line_state.length         = length_reg;
        line_state.starts_dollar  = starts_dollar_reg;
        line_state.running_xor    = running_xor_reg;
        line_state.star_seen      = star_seen_reg;
        line_state.hex_digit_seen = hex_digit_seen_reg;
        line_state.hex_acc        = hex_acc_reg;
        line_state.hex_too_large  = hex_too_large_reg;
        line_state.field_len      = field_len_reg;
        line_state.last_three     = last_three_reg;
    end

endmodule

// ----- rtl/core/nmea_chk_verdict.sv -----
// Verdict logic: sentence type lookup and checksum comparison for a finished line.
// Depends on nmea_chk_pkg.
module nmea_chk_verdict (
    input  nmea_chk_pkg::line_state_t line_state,
    output logic                      emit,
    output nmea_chk_pkg::verdict_t    verdict
);

    assign emit = (line_state.length != '0) && line_state.starts_dollar;

    always_comb begin
        verdict.sentence_type = nmea_chk_pkg::TYPE_OTHER;
        if (line_state.field_len == 2'd3) begin
            verdict.sentence_type = nmea_chk_pkg::classify(line_state.last_three);
        end

        verdict.computed_sum = line_state.running_xor;
        verdict.received_sum = 8'd0;
        verdict.check_status = nmea_chk_pkg::CHECK_NONE;
        if (line_state.star_seen) begin
            verdict.received_sum = line_state.hex_acc;
            if (line_state.hex_digit_seen && !line_state.hex_too_large &&
                line_state.hex_acc == line_state.running_xor) begin
                verdict.check_status = nmea_chk_pkg::CHECK_MATCH;
            end else begin
                verdict.check_status = nmea_chk_pkg::CHECK_MISMATCH;
            end
        end
    end

endmodule

// ----- rtl/core/nmea_sentence_checker_core.sv -----
// Top level of the NMEA sentence checker: byte input, line state, registered verdict output.
// Depends on nmea_chk_pkg, nmea_chk_line and nmea_chk_verdict.
//
//   Channel   Direction   Payload                                        Request
//   s_        in          rx_byte[7:0]                                   one received byte
//   m_        out         sentence_type, check_status, computed_sum,     one verdict per
//                         received_sum                                   '$' line
//
// One byte is accepted per cycle while s_ready is high; a verdict appears on m_ the cycle after its newline.
// aresetn is synchronous and active low; it clears the line state and the output valid.
// The only stall is a verdict held in the output register: s_ready drops while m_valid
// is high and m_ready is low.
module nmea_sentence_checker_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_sentence_type,
    output logic [1:0] m_check_status,
    output logic [7:0] m_computed_sum,
    output logic [7:0] m_received_sum
);

    nmea_chk_pkg::line_state_t line_state;
    nmea_chk_pkg::verdict_t    verdict;
    nmea_chk_pkg::verdict_t    out_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      line_done;
    logic                      s_accept;
    logic                      load_out;

    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    nmea_chk_line u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (s_accept),
        .rx_byte    (s_rx_byte),
        .line_state (line_state)
    );

    nmea_chk_verdict u_verdict (
        .line_state (line_state),
        .emit       (line_done),
        .verdict    (verdict)
    );

    assign load_out = s_accept && (s_rx_byte == nmea_chk_pkg::CH_LF) && line_done;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= verdict;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_sentence_type = out_reg.sentence_type;
    assign m_check_status  = out_reg.check_status;
    assign m_computed_sum  = out_reg.computed_sum;
    assign m_received_sum  = out_reg.received_sum;

endmodule
